// ===== rtl/fcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants of the footprint correlation correction block.
// ----------------------------------------------------------------------------
package fcc_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ELEM = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELEM_RD,
    ST_ELEM_MUL,
    ST_ELEM_ACC,
    ST_DIV,
    ST_REP_RD,
    ST_REP_MUL,
    ST_REP_WR,
    ST_READ_RD,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/fcc_divider.sv =====
// ----------------------------------------------------------------------------
// fcc_divider
// Restoring divider: signal * 2^34 / correlation, one quotient bit a cycle,
// saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module fcc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] signal,
  input  logic [63:0] corr,
  output logic        done,
  output logic [31:0] scale
);

  logic [65:0] num_r, num_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] den_r;
  logic [31:0] q_r, q_nxt;
  logic        big_r, big_nxt;
  logic        neg_r;
  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [64:0] shifted;
  logic [31:0] sig_abs;
  logic [63:0] corr_abs;

  assign sig_abs  = signal[31] ? (32'd0 - signal) : signal;
  assign corr_abs = corr[63] ? (64'd0 - corr) : corr;

  // One restoring step; cnt_r counts the quotient bit index down from 65.
  always_comb begin
    shifted = {rem_r[63:0], num_r[65]};
    num_nxt = {num_r[64:0], 1'b0};
    rem_nxt = shifted;
    q_nxt   = q_r;
    big_nxt = big_r;
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = shifted - {1'b0, den_r};
      if (cnt_r >= 7'd32) begin
        big_nxt = 1'b1;
      end else begin
        q_nxt[cnt_r[4:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd65;
        num_r  <= {sig_abs, 34'd0};
        rem_r  <= '0;
        den_r  <= corr_abs;
        q_r    <= '0;
        big_r  <= 1'b0;
        neg_r  <= signal[31] ^ corr[63];
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        big_r <= big_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Saturate the magnitude and apply the sign.
  always_comb begin
    if (neg_r) begin
      if (big_r || q_r[31]) scale = 32'h8000_0000;
      else                  scale = 32'd0 - q_r;
    end else begin
      if (big_r || q_r[31]) scale = 32'h7FFF_FFFF;
      else                  scale = q_r;
    end
  end

endmodule

// ===== rtl/footprint_correlation_correction.sv =====
// ----------------------------------------------------------------------------
// footprint_correlation_correction
// Maximum-correlation correction: correlate footprints with the image and
// scatter the scaled weights into a saturating correction store.
// ----------------------------------------------------------------------------
// Rate: one beat at a time. A load beat is written as it is accepted. A correction
// read steps through accept, memory read and output, a footprint element through
// accept, image read, multiply and accumulate. The last element adds a division
// and then a read-multiply-write per buffered element of the correction memory,
// whose single port sets the replay pace; a zero correlation skips both. A result
// still held in the output register stalls the next read or footprint end. Pixels
// never loaded read as undefined; no clearing pass is run.
module footprint_correlation_correction #(
  parameter int IMG_DIM  = 512,
  parameter int FOOT_MAX = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pixel_col[8:0], pixel_row[17:9], image_value[49:18],
  // response_value[67:50], sample_signal[99:68], zeros[103:100]
  input  logic [103:0] in_tdata,
  input  logic [1:0]   in_tuser,   // action
  input  logic         in_tlast,   // last_element
  output logic         out_tvalid,
  input  logic         out_tready,
  // correction_value[47:0], scale_value[79:48], zero_sum[80],
  // footprint_overflow[81], zeros[87:82]
  output logic [87:0]  out_tdata,
  output logic         out_tuser   // result_kind
);

  localparam int AW = $clog2(IMG_DIM);
  localparam int PW = 2 * AW;
  localparam int NPIX = IMG_DIM * IMG_DIM;
  localparam int FW = $clog2(FOOT_MAX);
  localparam int CW = FW + 1;

  fcc_pkg::state_t state_r, state_nxt;

  // Input fields.
  logic [1:0]  act;
  logic [8:0]  col, row;
  logic [31:0] img_v, sig_v;
  logic [17:0] wgt_v;
  assign act   = in_tuser;
  assign col   = in_tdata[8:0];
  assign row   = in_tdata[17:9];
  assign img_v = in_tdata[49:18];
  assign wgt_v = in_tdata[67:50];
  assign sig_v = in_tdata[99:68];

  // Memories.
  logic [31:0]   img_mem  [NPIX];
  logic [47:0]   corr_mem [NPIX];
  logic [PW+18:0] foot_mem [FOOT_MAX];  // {in image, pixel, weight}

  logic [31:0]   img_rd_r;
  logic [47:0]   corr_rd_r;
  logic [PW+18:0] foot_rd_r;

  // Item registers.
  logic [PW-1:0] pix_r;
  logic          in_img_r;
  logic [17:0]   wgt_r;
  logic [31:0]   sig_r;
  logic          last_r;
  logic [1:0]    act_r;
  logic [CW-1:0] cnt_r, rep_r;
  logic [63:0]   sum_r;
  logic          ovf_r;
  logic signed [50:0] prod_r;
  logic [31:0]   scale_r;
  logic          zero_r;
  logic [87:0]   odata_r;
  logic          okind_r;
  logic          ovalid_r;

  logic          in_img;
  logic [PW-1:0] pix_in;
  assign in_img = ({23'd0, col} < 32'(IMG_DIM)) && ({23'd0, row} < 32'(IMG_DIM));
  assign pix_in = PW'({23'd0, row} * 32'(IMG_DIM) + {23'd0, col});

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [63:0] sum_upd;

  fcc_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .signal (sig_r),
    .corr   (sum_upd),
    .done   (div_done),
    .scale  (div_q)
  );

  assign in_tready  = (state_r == fcc_pkg::ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = okind_r;

  logic acc;
  assign acc = in_tvalid && in_tready;

  // Sum with 64-bit saturation.
  logic signed [63:0] prod64, sum_add;
  logic               sum_ov;
  assign prod64  = 64'(prod_r);
  assign sum_add = $signed(sum_r) + prod64;
  assign sum_ov  = (sum_r[63] == prod64[63]) && (sum_add[63] != sum_r[63]);

  // Correlation after the current element; dropped elements leave it as is.
  logic zero_nxt;
  always_comb begin
    sum_upd = sum_r;
    if (cnt_r < CW'(FOOT_MAX)) begin
      if (sum_ov) sum_upd = sum_r[63] ? 64'h8000_0000_0000_0000
                                      : 64'h7FFF_FFFF_FFFF_FFFF;
      else        sum_upd = sum_add;
    end
  end
  assign zero_nxt = (sum_upd == 64'd0);

  // Correction with 48-bit saturation.
  logic signed [51:0] corr_add;
  logic [47:0]        corr_sat;
  assign corr_add = 52'($signed(corr_rd_r)) + 52'(prod_r);
  always_comb begin
    if (corr_add > 52'sh7FFF_FFFF_FFFF)       corr_sat = 48'h7FFF_FFFF_FFFF;
    else if (corr_add < -52'sh8000_0000_0000) corr_sat = 48'h8000_0000_0000;
    else                                       corr_sat = corr_add[47:0];
  end

  logic rep_done;
  assign rep_done = (rep_r == cnt_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      fcc_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (act)
            fcc_pkg::ACT_ELEM: state_nxt = fcc_pkg::ST_ELEM_RD;
            fcc_pkg::ACT_READ: state_nxt = fcc_pkg::ST_READ_RD;
            default:           state_nxt = fcc_pkg::ST_IDLE;
          endcase
        end
      end
      fcc_pkg::ST_ELEM_RD:  state_nxt = fcc_pkg::ST_ELEM_MUL;
      fcc_pkg::ST_ELEM_MUL: state_nxt = fcc_pkg::ST_ELEM_ACC;
      fcc_pkg::ST_ELEM_ACC: begin
        if (!last_r)       state_nxt = fcc_pkg::ST_IDLE;
        else if (zero_nxt) state_nxt = fcc_pkg::ST_OUT;
        else               state_nxt = fcc_pkg::ST_DIV;
      end
      fcc_pkg::ST_DIV: begin
        if (div_done) state_nxt = rep_done ? fcc_pkg::ST_OUT : fcc_pkg::ST_REP_RD;
      end
      fcc_pkg::ST_REP_RD:  state_nxt = fcc_pkg::ST_REP_MUL;
      fcc_pkg::ST_REP_MUL: state_nxt = fcc_pkg::ST_REP_WR;
      fcc_pkg::ST_REP_WR:  state_nxt = rep_done ? fcc_pkg::ST_OUT : fcc_pkg::ST_REP_RD;
      fcc_pkg::ST_READ_RD: state_nxt = fcc_pkg::ST_OUT;
      fcc_pkg::ST_OUT:     if (!ovalid_r || out_tready) state_nxt = fcc_pkg::ST_IDLE;
      default:             state_nxt = fcc_pkg::ST_IDLE;
    endcase
    // Kick the divider on entry to ST_DIV.
    if (state_r == fcc_pkg::ST_ELEM_ACC && state_nxt == fcc_pkg::ST_DIV) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fcc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Image memory: write on load, read on element.
  always_ff @(posedge clk) begin
    if (acc && act == fcc_pkg::ACT_LOAD && in_img) img_mem[pix_in] <= img_v;
    img_rd_r <= img_mem[pix_r];
  end

  // Footprint buffer: write on accepted element, read during replay.
  always_ff @(posedge clk) begin
    if (state_r == fcc_pkg::ST_ELEM_RD && cnt_r < CW'(FOOT_MAX))
      foot_mem[cnt_r[FW-1:0]] <= {in_img_r, pix_r, wgt_r};
    foot_rd_r <= foot_mem[rep_r[FW-1:0]];
  end

  // Correction memory: clear on load, saturating add on replay.
  // During replay, read the pixel of the buffer entry that just came out.
  logic [PW-1:0] corr_addr;
  assign corr_addr = (state_r == fcc_pkg::ST_REP_MUL) ? foot_rd_r[PW+17:18] : pix_r;
  always_ff @(posedge clk) begin
    if (acc && act == fcc_pkg::ACT_LOAD && in_img) corr_mem[pix_in] <= '0;
    else if (state_r == fcc_pkg::ST_REP_WR && in_img_r) corr_mem[pix_r] <= corr_sat;
    corr_rd_r <= corr_mem[corr_addr];
  end

  // Output register: load a result in ST_OUT, drop it once taken.
  always_ff @(posedge clk) begin
    if (!rst_n)
      ovalid_r <= 1'b0;
    else if (state_r == fcc_pkg::ST_OUT && (!ovalid_r || out_tready))
      ovalid_r <= 1'b1;
    else if (out_tready)
      ovalid_r <= 1'b0;
  end

  // Datapath and bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
      rep_r    <= '0;
    end else begin
      unique case (state_r)
        fcc_pkg::ST_IDLE: begin
          if (acc) begin
            act_r    <= act;
            pix_r    <= pix_in;
            in_img_r <= in_img;
            wgt_r    <= wgt_v;
            sig_r    <= sig_v;
            last_r   <= in_tlast;
          end
        end
        fcc_pkg::ST_ELEM_MUL: begin
          // Out-of-image pixels count as zero.
          prod_r <= (in_img_r && cnt_r < CW'(FOOT_MAX)) ?
                    51'($signed(img_rd_r) * $signed({1'b0, wgt_r})) : '0;
          if (cnt_r >= CW'(FOOT_MAX)) ovf_r <= 1'b1;
        end
        fcc_pkg::ST_ELEM_ACC: begin
          if (cnt_r < CW'(FOOT_MAX)) cnt_r <= cnt_r + CW'(1);
          sum_r <= sum_upd;
          rep_r <= '0;
          if (last_r && zero_nxt) begin
            scale_r <= '0;
            zero_r  <= 1'b1;
          end
        end
        fcc_pkg::ST_DIV: begin
          zero_r <= 1'b0;
          if (div_done) scale_r <= div_q;
        end
        fcc_pkg::ST_REP_RD: begin
          rep_r <= rep_r + CW'(1);
        end
        fcc_pkg::ST_REP_MUL: begin
          {in_img_r, pix_r} <= foot_rd_r[PW+18:18];
          prod_r <= 51'($signed(scale_r) * $signed({1'b0, foot_rd_r[17:0]}));
        end
        fcc_pkg::ST_OUT: begin
          if (!ovalid_r || out_tready) begin
            if (act_r == fcc_pkg::ACT_READ) begin
              okind_r <= 1'b0;
              odata_r <= {40'd0, in_img_r ? corr_rd_r : 48'd0};
            end else begin
              okind_r <= 1'b1;
              odata_r <= {6'd0, ovf_r, zero_r, scale_r, 48'd0};
              cnt_r   <= '0;
              sum_r   <= '0;
              ovf_r   <= 1'b0;
              rep_r   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FOOT_MAX)) else $error("footprint count beyond buffer");
  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r <= cnt_r) else $error("replay past footprint");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != fcc_pkg::ST_IDLE |-> !in_tready) else $error("ready while busy");

endmodule
